@@ sv/dns_query_name_extractor_macros.svh @@
// assertion macros used by the checker file
`ifndef DNS_QUERY_NAME_EXTRACTOR_MACROS_SVH
`define DNS_QUERY_NAME_EXTRACTOR_MACROS_SVH

// property checked at every clock edge outside reset
`define DQNE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define DQNE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/dqne_pkg.sv @@
// types and constants of the dns query name extractor
`timescale 1ns / 1ps

package dqne_pkg;

  localparam int DomainMax = 256;
  localparam int NameMax   = DomainMax - 1;
  localparam int NameLenW  = $clog2(DomainMax);
  localparam int HdrBytes  = 12;
  localparam int HdrCntW   = $clog2(HdrBytes);

  // question count sits at header bytes 4 and 5
  localparam logic [HdrCntW-1:0] QdCountHi = HdrCntW'(4);
  localparam logic [HdrCntW-1:0] QdCountLo = HdrCntW'(5);
  localparam logic [HdrCntW-1:0] HdrLast   = HdrCntW'(HdrBytes - 1);

  localparam logic [7:0] DotChar = 8'h2e;

  localparam logic [7:0] ResetMaxPlain = 8'd17;
  localparam logic [7:0] ResetExtraA   = 8'd65;
  localparam logic [7:0] ResetExtraB   = 8'd28;

  localparam logic KindChar    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CFG_MAX_PLAIN = 2'd0,
    CFG_EXTRA_A   = 2'd1,
    CFG_EXTRA_B   = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_TAIL   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] max_plain;
    logic [7:0] extra_a;
    logic [7:0] extra_b;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_char;
    logic       accepted;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t    first;
    result_t    second;
    logic [1:0] count;
  } emit_t;

endpackage

@@ sv/dqne_parse.sv @@
// per-packet parse state and the result logic for one byte
`timescale 1ns / 1ps

module dqne_parse import dqne_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_packet_i,
  input  cfg_t       cfg_i,
  output emit_t      emit_o
);

  phase_e                phase_q, phase_d;
  logic [HdrCntW-1:0]    cnt_q, cnt_d;
  logic                  qn_q, qn_d;
  logic [7:0]            label_q, label_d;
  logic [NameLenW-1:0]   len_q, len_d;
  logic                  first_q, first_d;
  logic                  ovf_q, ovf_d;
  logic                  type_ok_q, type_ok_d;

  logic       put;
  logic [7:0] put_val;
  logic       char_vld;
  logic [7:0] label_dec;
  result_t    char_res;
  result_t    verdict_res;

  assign label_dec = label_q - 8'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    qn_d      = qn_q;
    label_d   = label_q;
    len_d     = len_q;
    first_d   = first_q;
    ovf_d     = ovf_q;
    type_ok_d = type_ok_q;
    put       = 1'b0;
    put_val   = data_byte_i;
    char_vld  = 1'b0;

    case (phase_q)
      PH_HEADER: begin
        if ((cnt_q == QdCountHi || cnt_q == QdCountLo) && data_byte_i != 8'd0) begin
          qn_d = 1'b1;
        end
        cnt_d = cnt_q + HdrCntW'(1);
        if (cnt_q == HdrLast) begin
          cnt_d   = '0;
          phase_d = qn_d ? PH_LEN : PH_DONE;
        end
      end
      PH_LEN: begin
        if (data_byte_i == 8'd0) begin
          cnt_d   = '0;
          phase_d = PH_TAIL;
        end else begin
          put     = !first_q;
          put_val = DotChar;
          first_d = 1'b0;
          label_d = data_byte_i;
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        put     = 1'b1;
        label_d = label_dec;
        if (label_dec == 8'd0) begin
          phase_d = PH_LEN;
        end
      end
      PH_TAIL: begin
        // second byte after the zero label is the low byte of the type
        if (cnt_q == '0) begin
          cnt_d = HdrCntW'(1);
        end else begin
          type_ok_d = (data_byte_i <= cfg_i.max_plain) || (data_byte_i == cfg_i.extra_a) ||
                      (data_byte_i == cfg_i.extra_b);
          phase_d   = PH_DONE;
        end
      end
      default: ;
    endcase

    if (put && !ovf_q) begin
      if (len_q == NameLenW'(NameMax)) begin
        ovf_d = 1'b1;
      end else begin
        len_d    = len_q + NameLenW'(1);
        char_vld = 1'b1;
      end
    end

    char_res.kind      = KindChar;
    char_res.name_char = put_val;
    char_res.accepted  = 1'b0;
    char_res.last      = 1'b0;

    verdict_res.kind      = KindVerdict;
    verdict_res.name_char = 8'd0;
    verdict_res.accepted  = qn_d && type_ok_d && !ovf_d;
    verdict_res.last      = 1'b1;

    emit_o.first  = char_vld ? char_res : verdict_res;
    emit_o.second = verdict_res;
    emit_o.count  = 2'(char_vld) + 2'(end_of_packet_i);
    if (!item_valid_i) begin
      emit_o.count = 2'd0;
    end

    if (end_of_packet_i) begin
      phase_d   = PH_HEADER;
      cnt_d     = '0;
      qn_d      = 1'b0;
      label_d   = 8'd0;
      len_d     = '0;
      first_d   = 1'b1;
      ovf_d     = 1'b0;
      type_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      cnt_q     <= '0;
      qn_q      <= 1'b0;
      label_q   <= 8'd0;
      len_q     <= '0;
      first_q   <= 1'b1;
      ovf_q     <= 1'b0;
      type_ok_q <= 1'b0;
    end else if (item_valid_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      qn_q      <= qn_d;
      label_q   <= label_d;
      len_q     <= len_d;
      first_q   <= first_d;
      ovf_q     <= ovf_d;
      type_ok_q <= type_ok_d;
    end
  end

endmodule

@@ sv/dns_query_name_extractor.sv @@
// Flow: an accepted byte is registered in the input stage and parsed from there once the
// result queue has room; its results are shown from the queue, one result per cycle
// while out_ready_i is high. Throughput: one byte per cycle while the queue has room; a
// byte that gives two results (last name character and verdict) is absorbed by the
// four-entry result queue. Reset: parse state returns to the header phase, the queue
// empties, and the type registers load 17, 65 and 28.
`timescale 1ns / 1ps

module dns_query_name_extractor import dqne_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_packet_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_kind_o,
  output logic [7:0] name_char_o,
  output logic       accepted_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t cfg_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eop_q;

  result_t              queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  logic    room;
  logic    fire;
  logic    pop;
  emit_t   emit;
  result_t head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_plain <= ResetMaxPlain;
      cfg_q.extra_a   <= ResetExtraA;
      cfg_q.extra_b   <= ResetExtraB;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_PLAIN: cfg_q.max_plain <= cfg_data_i;
        CFG_EXTRA_A:   cfg_q.extra_a   <= cfg_data_i;
        CFG_EXTRA_B:   cfg_q.extra_b   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // worst case a byte pushes two results
  assign room       = cnt_q <= QueueCntW'(QueueDepth - 2);
  assign fire       = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
      s1_eop_q  <= end_of_packet_i;
    end
  end

  dqne_parse u_parse (
    .clk_i,
    .rst_ni,
    .item_valid_i    (fire),
    .data_byte_i     (s1_byte_q),
    .end_of_packet_i (s1_eop_q),
    .cfg_i           (cfg_q),
    .emit_o          (emit)
  );

  assign head        = queue_q[rd_ptr_q];
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;

  assign result_kind_o = head.kind;
  assign name_char_o   = head.name_char;
  assign accepted_o    = head.accepted;
  assign last_o        = head.last;

  always_ff @(posedge clk_i) begin
    if (emit.count != 2'd0) begin
      queue_q[wr_ptr_q] <= emit.first;
    end
    if (emit.count == 2'd2) begin
      queue_q[wr_ptr_q + QueuePtrW'(1)] <= emit.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(emit.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      cnt_q <= cnt_q + QueueCntW'(emit.count) - QueueCntW'(pop);
    end
  end

endmodule

@@ sv/dqne_checker.sv @@
// port checks of the dns query name extractor and their bind
`timescale 1ns / 1ps
`include "dns_query_name_extractor_macros.svh"

module dqne_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       result_kind_o,
  input logic [7:0] name_char_o,
  input logic       accepted_o,
  input logic       last_o
);

  // nothing to deliver while held in reset, the first edge may still see unknown state
  `DQNE_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> out_valid_o !== 1'b1, "result during reset")

  // a verdict closes the packet and carries no character
  `DQNE_ASSERT(a_verdict_form, out_valid_o && result_kind_o |-> last_o && name_char_o == 8'd0,
               "malformed verdict")

  // a name character is never last and never accepted
  `DQNE_ASSERT(a_char_form, out_valid_o && !result_kind_o |-> !last_o && !accepted_o,
               "malformed name character")

  // a stalled result holds
  `DQNE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o &&
               $stable(result_kind_o) && $stable(name_char_o) && $stable(accepted_o) &&
               $stable(last_o), "stalled result changed")

  // no result is shown in the cycle in which reset is seen released
  `DQNE_ASSERT(a_no_early_out, $rose(rst_ni) |-> !out_valid_o, "result right after reset")

endmodule

bind dns_query_name_extractor dqne_checker u_dqne_checker (.*);
